FILE: rtl/core/f12cc_pkg.sv
// ============================================================================
// f12cc_pkg
// Shared types and constants for the FAT12 cluster chain step block.
// ============================================================================
`default_nettype none

package f12cc_pkg;

    // Operation codes carried in the op field of an input transaction.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_FOLLOW = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [31:0] DATA_START_RESET = 32'd33;
    localparam logic [7:0]  SPC_RESET        = 8'd1;

    // Allocation table constants.
    localparam logic [11:0]        ENTRY_MASK         = 12'hFFF;
    localparam logic [11:0]        END_MARK           = 12'hFF8;
    localparam logic signed [12:0] FIRST_DATA_CLUSTER = 13'sd2;
    localparam int                 ODD_SHIFT          = 4;

    // One input transaction.
    typedef struct packed {
        logic        op;
        logic [12:0] table_address;
        logic [7:0]  table_byte;
        logic [11:0] cluster;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] lba;
        logic [11:0] next_cluster;
        logic        chain_end;
    } result_t;

    // A classified transaction as it travels from the front to the back.
    // The table is split into an even-byte bank and an odd-byte bank.
    typedef struct packed {
        logic               follow;
        logic [11:0]        even_addr;
        logic [11:0]        odd_addr;
        logic               even_ok;
        logic               odd_ok;
        logic               cl_odd;
        logic               low_is_odd;
        logic signed [12:0] offset;
        logic [7:0]         wdata;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic occupied;
        logic push;
    } front_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/f12cc_ram.sv
// ============================================================================
// f12cc_ram
// Generic single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module f12cc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3072
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/f12cc_front.sv
// ============================================================================
// f12cc_front
// Accepts transactions and classifies them into bank accesses for the back.
// ============================================================================
`default_nettype none

module f12cc_front #(
    parameter int TABLE_BYTES = 6144
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire f12cc_pkg::in_item_t       item,
    input  wire logic                      queue_full,
    output logic                           busy,
    output f12cc_pkg::work_t               work,
    output f12cc_pkg::front_status_t       status
);

    localparam logic [13:0] TB_LIM = 14'(TABLE_BYTES);

    f12cc_pkg::in_item_t item_reg;
    logic                valid_reg;
    logic                valid_next;
    logic                take;
    logic                push;

    logic [12:0] idx;
    logic [12:0] idx_hi;
    logic [11:0] base;
    logic [11:0] base_p1;
    logic        lo_in;
    logic        hi_in;
    logic        wr_in;

    assign busy = valid_reg && queue_full;
    assign take = start && !busy;
    assign push = valid_reg && !queue_full;
    assign valid_next = take || (valid_reg && !push);

    assign status.occupied = valid_reg;
    assign status.push     = push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    // The entry sits at byte cluster + cluster/2 and spans two bytes,
    // which always fall in different banks.
    assign idx     = {1'b0, item_reg.cluster} + {2'b00, item_reg.cluster[11:1]};
    assign idx_hi  = idx + 13'd1;
    assign base    = idx[12:1];
    assign base_p1 = base + 12'd1;
    assign lo_in   = {1'b0, idx} < TB_LIM;
    assign hi_in   = {1'b0, idx_hi} < TB_LIM;
    assign wr_in   = {1'b0, item_reg.table_address} < TB_LIM;

    always_comb
    begin
        work.follow     = (item_reg.op == f12cc_pkg::OP_FOLLOW);
        work.cl_odd     = item_reg.cluster[0];
        work.low_is_odd = idx[0];
        work.offset     = $signed({1'b0, item_reg.cluster}) - f12cc_pkg::FIRST_DATA_CLUSTER;
        work.wdata      = item_reg.table_byte;
        if (item_reg.op == f12cc_pkg::OP_FOLLOW)
        begin
            work.odd_addr = base;
            if (idx[0])
            begin
                work.even_addr = base_p1;
                work.odd_ok    = lo_in;
                work.even_ok   = hi_in;
            end
            else
            begin
                work.even_addr = base;
                work.even_ok   = lo_in;
                work.odd_ok    = hi_in;
            end
        end
        else
        begin
            work.even_addr = item_reg.table_address[12:1];
            work.odd_addr  = item_reg.table_address[12:1];
            work.even_ok   = wr_in && !item_reg.table_address[0];
            work.odd_ok    = wr_in && item_reg.table_address[0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/f12cc_queue.sv
// ============================================================================
// f12cc_queue
// Two-entry queue of classified transactions between the front and the back.
// ============================================================================
`default_nettype none

module f12cc_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire f12cc_pkg::work_t      push_work,
    input  wire logic                  pop,
    output f12cc_pkg::work_t           head,
    output f12cc_pkg::queue_status_t   status
);

    f12cc_pkg::work_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/f12cc_back.sv
// ============================================================================
// f12cc_back
// Executes classified transactions: table bank access, entry decode and the
// sector address computation.
// ============================================================================
`default_nettype none

module f12cc_back #(
    parameter int TABLE_BYTES = 6144
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pop,
    input  wire f12cc_pkg::work_t   work,
    input  wire logic [31:0]        data_start,
    input  wire logic [7:0]         spc,
    output logic                    done,
    output f12cc_pkg::result_t      result
);

    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    logic [7:0] even_q;
    logic [7:0] odd_q;
    logic       even_we;
    logic       odd_we;

    // Stage 1: bank data returns.
    logic               s1_valid_reg;
    logic               s1_cl_odd_reg;
    logic               s1_low_is_odd_reg;
    logic               s1_even_ok_reg;
    logic               s1_odd_ok_reg;
    logic signed [12:0] s1_offset_reg;

    // Stage 2: entry decoded, product formed.
    logic               s2_valid_reg;
    logic [11:0]        s2_next_reg;
    logic [11:0]        s2_next_next;
    logic signed [21:0] s2_prod_reg;
    logic signed [21:0] s2_prod_next;

    logic        done_reg;
    f12cc_pkg::result_t result_reg;
    f12cc_pkg::result_t result_next;

    logic [7:0]  even_byte;
    logic [7:0]  odd_byte;
    logic [15:0] word;

    assign even_we = !work.follow && work.even_ok;
    assign odd_we  = !work.follow && work.odd_ok;

    f12cc_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .en    (pop),
        .we    (even_we),
        .addr  (work.even_addr[BANK_AW-1:0]),
        .wdata (work.wdata),
        .rdata (even_q)
    );

    f12cc_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .en    (pop),
        .we    (odd_we),
        .addr  (work.odd_addr[BANK_AW-1:0]),
        .wdata (work.wdata),
        .rdata (odd_q)
    );

    // Bytes past the end of the table read as zero.
    always_comb
    begin
        even_byte = s1_even_ok_reg ? even_q : 8'd0;
        odd_byte  = s1_odd_ok_reg ? odd_q : 8'd0;
        word      = s1_low_is_odd_reg ? {even_byte, odd_byte} : {odd_byte, even_byte};
        if (s1_cl_odd_reg)
        begin
            s2_next_next = word[15:f12cc_pkg::ODD_SHIFT] & f12cc_pkg::ENTRY_MASK;
        end
        else
        begin
            s2_next_next = word[11:0] & f12cc_pkg::ENTRY_MASK;
        end
        s2_prod_next = s1_offset_reg * $signed({1'b0, spc});
    end

    always_comb
    begin
        result_next.lba          = data_start + {{10{s2_prod_reg[21]}}, s2_prod_reg};
        result_next.next_cluster = s2_next_reg;
        result_next.chain_end    = (s2_next_reg >= f12cc_pkg::END_MARK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop && work.follow;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cl_odd_reg     <= work.cl_odd;
        s1_low_is_odd_reg <= work.low_is_odd;
        s1_even_ok_reg    <= work.even_ok;
        s1_odd_ok_reg     <= work.odd_ok;
        s1_offset_reg     <= work.offset;
        s2_next_reg       <= s2_next_next;
        s2_prod_reg       <= s2_prod_next;
        result_reg        <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fat12_cluster_chain_step.sv
// ============================================================================
// fat12_cluster_chain_step
// FAT12 allocation table store with cluster lookup and sector address output.
// ============================================================================
// Usage: a transaction is taken at a rising edge where start is high and busy
// is low. A write transaction (op = write) stores one allocation table byte
// and gives no result. A follow transaction (op = follow) gives exactly one
// result: the first sector of the cluster, its 12-bit table entry and an
// end-of-chain flag. Results appear in order on result for exactly one cycle,
// marked by done; the receiver has no way to hold them off, so it must take
// every one. One transaction can be taken every clock cycle, and busy stays
// low as long as transactions keep flowing. That rate is set by the table
// store, which is split into an even-byte bank and an odd-byte bank so that
// the two bytes of an entry come out of one single-port access each. Table
// bytes must be written before a follow reads them; the store has no reset.
// The user must write configuration registers through cfg_valid/cfg_ready
// only while no transaction is in flight; the block does not enforce this.
// ============================================================================
`default_nettype none

module fat12_cluster_chain_step #(
    parameter int TABLE_BYTES = 6144
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire f12cc_pkg::in_item_t                  item,
    output logic                                      done,
    output f12cc_pkg::result_t                        result,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [f12cc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                          cfg_data
);

    // Configuration registers. The port never pushes back on a write.
    logic [31:0] data_start_reg;
    logic [31:0] data_start_next;
    logic [7:0]  spc_reg;
    logic [7:0]  spc_next;

    f12cc_pkg::work_t          front_work;
    f12cc_pkg::work_t          queue_head;
    f12cc_pkg::front_status_t  front_st;
    f12cc_pkg::queue_status_t  queue_st;
    logic                      queue_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        data_start_next = data_start_reg;
        spc_next        = spc_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                f12cc_pkg::CFG_DATA_START: data_start_next = cfg_data;
                f12cc_pkg::CFG_SPC:        spc_next        = cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_start_reg <= f12cc_pkg::DATA_START_RESET;
            spc_reg        <= f12cc_pkg::SPC_RESET;
        end
        else
        begin
            data_start_reg <= data_start_next;
            spc_reg        <= spc_next;
        end
    end

    // The front registers each transaction and works out which bank entries
    // it touches, then hands it to the queue.
    f12cc_front #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .queue_full (queue_st.full),
        .busy       (busy),
        .work       (front_work),
        .status     (front_st)
    );

    f12cc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_st.push),
        .push_work (front_work),
        .pop       (queue_pop),
        .head      (queue_head),
        .status    (queue_st)
    );

    // The back never stalls, so it drains the queue whenever it holds work.
    assign queue_pop = !queue_st.empty;

    f12cc_back #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (queue_pop),
        .work       (queue_head),
        .data_start (data_start_reg),
        .spc        (spc_reg),
        .done       (done),
        .result     (result)
    );

    // The queue can never report full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_st.full && queue_st.empty))
        else $error("queue reports full and empty together");

    // The front only hands over work when the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        front_st.push |-> !queue_st.full)
        else $error("front pushed into a full queue");

    // Busy is only raised while the front holds a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> front_st.occupied)
        else $error("busy raised with an empty front stage");

    // Every result strobe traces back to a follow transaction leaving the
    // queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(queue_pop && queue_head.follow, 3))
        else $error("result strobe without a matching follow transaction");

endmodule

`default_nettype wire

FILE: dv/fat12_cluster_chain_step_tb.sv
// ============================================================================
// fat12_cluster_chain_step_tb
// Self-checking testbench for the FAT12 cluster chain step block. It fills
// allocation table bytes through write transactions, follows clusters whose
// table bytes are known, and compares every result against a predictor kept
// in a small scoreboard class. The run covers the reset settings, the extremes
// of both configuration registers, unused register indexes and writes beyond
// the end of the table.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module fat12_cluster_chain_step_tb;

    localparam int TABLE_BYTES  = 6144;
    localparam int ADDR_SPAN    = 8192;   // every value the 13-bit address field can hold
    localparam int SETTLE_CYCLES = 8;     // time for results to show up after acceptance
    localparam int STALL_LIMIT  = 2000;   // cycles without any handshake before giving up
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 6;

    // Register indexes that the block does not implement; writes must be dropped.
    localparam logic [f12cc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [f12cc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the table and the registers, and the queue of
    // results that follow transactions are still owed.
    // ------------------------------------------------------------------------
    class fat_table_scoreboard;
        logic [7:0]           fat_bytes [TABLE_BYTES];
        bit                   written [TABLE_BYTES];
        logic [31:0]          data_start;
        logic [7:0]           spc;
        f12cc_pkg::result_t   owed_q[$];
        int                   errors;

        function new();
            data_start = f12cc_pkg::DATA_START_RESET;
            spc        = f12cc_pkg::SPC_RESET;
            errors     = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(logic [f12cc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == f12cc_pkg::CFG_DATA_START)
                data_start = data;
            else if (idx == f12cc_pkg::CFG_SPC)
                spc = data[7:0];
        endfunction

        // Bytes past the end of the table read as zero.
        function logic [7:0] read_byte(int unsigned addr);
            if (addr < TABLE_BYTES)
                return fat_bytes[addr];
            return 8'h00;
        endfunction

        // A follow may only be issued when both bytes of the entry are known.
        function bit can_follow(logic [11:0] cl);
            int unsigned idx;
            idx = cl + (cl >> 1);
            return (idx >= TABLE_BYTES || written[idx]) &&
                   (idx + 1 >= TABLE_BYTES || written[idx + 1]);
        endfunction

        function void note_item(f12cc_pkg::in_item_t it);
            int unsigned        idx;
            logic [15:0]        word;
            logic [31:0]        rel;
            f12cc_pkg::result_t r;
            if (it.op == f12cc_pkg::OP_WRITE)
            begin
                if (it.table_address < TABLE_BYTES)
                begin
                    fat_bytes[it.table_address] = it.table_byte;
                    written[it.table_address]   = 1'b1;
                end
                return;
            end
            // Clusters 0 and 1 make the relative offset wrap around 2^32.
            rel   = {20'd0, it.cluster} - 32'd2;
            r.lba = data_start + rel * {24'd0, spc};
            idx   = it.cluster + (it.cluster >> 1);
            word  = {read_byte(idx + 1), read_byte(idx)};
            r.next_cluster = it.cluster[0] ? word[15:4] : word[11:0];
            r.chain_end    = (r.next_cluster >= f12cc_pkg::END_MARK);
            owed_q.push_back(r);
        endfunction

        function void check_result(f12cc_pkg::result_t got);
            f12cc_pkg::result_t want;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result: lba %h next_cluster %h chain_end %b",
                       got.lba, got.next_cluster, got.chain_end);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.lba !== want.lba)
            begin
                $error("lba mismatch: expected %h, got %h", want.lba, got.lba);
                errors++;
            end
            if (got.next_cluster !== want.next_cluster)
            begin
                $error("next_cluster mismatch: expected %h, got %h",
                       want.next_cluster, got.next_cluster);
                errors++;
            end
            if (got.chain_end !== want.chain_end)
            begin
                $error("chain_end mismatch: expected %b, got %b",
                       want.chain_end, got.chain_end);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block itself.
    // ------------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    f12cc_pkg::in_item_t             item;
    logic                            done;
    f12cc_pkg::result_t              result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [f12cc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                     cfg_data;

    fat_table_scoreboard chain_sb = new();

    // Clusters whose two table bytes were written by a chain sequence.
    int known_clusters[$];

    // Percentage of cycles in which the sender stays idle in the current phase.
    int idle_pct;

    int stall_cycles;

    fat12_cluster_chain_step #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Results are valid for exactly one cycle; the receiver can never stall,
    // so every strobe is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            chain_sb.check_result(result);
    end

    // Watchdog: counts cycles in which no transaction of any kind completes.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered at a falling edge and returns at one, so
    // inputs always change half a period away from the sampling edge. start
    // and cfg_valid stay high across back-to-back transactions and are lowered
    // only between them, never in the same step they are raised again.
    // ------------------------------------------------------------------------
    task automatic send_item(input f12cc_pkg::in_item_t it);
        // Each cycle slot is left idle with the phase's idle percentage.
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        chain_sb.note_item(it);
        @(negedge clk);
    endtask

    // Write transaction; the cluster field carries random filler.
    task automatic write_byte(input int unsigned addr, input logic [7:0] data);
        f12cc_pkg::in_item_t it;
        it.op            = f12cc_pkg::OP_WRITE;
        it.table_address = addr[12:0];
        it.table_byte    = data;
        it.cluster       = 12'($urandom);
        send_item(it);
    endtask

    // Follow transaction; the address and byte fields carry random filler.
    task automatic follow(input logic [11:0] cl);
        f12cc_pkg::in_item_t it;
        it.op            = f12cc_pkg::OP_FOLLOW;
        it.table_address = 13'($urandom);
        it.table_byte    = 8'($urandom);
        it.cluster       = cl;
        send_item(it);
    endtask

    // Stops sending until every owed result is in, then lets extra cycles pass
    // so that trailing write transactions leave the pipeline as well.
    task automatic drain(input int extra);
        start <= 1'b0;
        while (chain_sb.pending() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(input logic [f12cc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        chain_sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Programs both registers while the block is idle. The upper bits of the
    // sectors-per-cluster write carry junk that the block must drop. An
    // optional write to an unused index must change nothing.
    task automatic program_regs(input logic [31:0] start_lba, input logic [7:0] spc,
                                input bit poke_unused,
                                input logic [f12cc_pkg::CFG_IDX_W-1:0] unused_idx);
        write_reg(f12cc_pkg::CFG_DATA_START, start_lba);
        write_reg(f12cc_pkg::CFG_SPC, {24'($urandom), spc});
        if (poke_unused)
            write_reg(unused_idx, $urandom);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // A well-formed lookup: write both bytes of a cluster's entry, in random
    // order, then follow it. A quarter of the entries are end-of-chain marks,
    // which random bytes alone would almost never produce. The other nibble
    // of the shared byte belongs to the neighboring entry and is random.
    task automatic chain_sequence();
        logic [11:0] cl;
        logic [11:0] entry;
        logic [3:0]  other;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int unsigned idx;
        cl    = 12'($urandom);
        entry = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(12'hFF8, 12'hFFF))
                                            : 12'($urandom);
        other = 4'($urandom);
        idx   = cl + (cl >> 1);
        if (cl[0])
        begin
            lo = {entry[3:0], other};
            hi = entry[11:4];
        end
        else
        begin
            lo = entry[7:0];
            hi = {other, entry[11:8]};
        end
        if ($urandom_range(0, 1) == 0)
        begin
            write_byte(idx, lo);
            write_byte(idx + 1, hi);
        end
        else
        begin
            write_byte(idx + 1, hi);
            write_byte(idx, lo);
        end
        follow(cl);
        known_clusters.push_back(cl);
    endtask

    // Random traffic: mostly write-then-follow sequences, then repeat lookups
    // of known clusters, stray table writes, and writes past the table end,
    // which are ignored and do not count toward the target. Once per phase the
    // sender holds off until all owed results have arrived.
    task automatic random_phase(input int target);
        int count;
        int pause_at;
        int sel;
        bit paused;
        count    = 0;
        paused   = 1'b0;
        pause_at = $urandom_range(target / 5, (4 * target) / 5);
        while (count < target)
        begin
            if (!paused && count >= pause_at)
            begin
                drain(1);
                paused = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 50 || known_clusters.size() == 0)
            begin
                chain_sequence();
                count += 3;
            end
            else if (sel < 80)
            begin
                follow(12'(known_clusters[$urandom_range(0, known_clusters.size() - 1)]));
                count++;
            end
            else if (sel < 95)
            begin
                write_byte($urandom_range(0, TABLE_BYTES - 1), 8'($urandom));
                count++;
            end
            else
            begin
                write_byte($urandom_range(TABLE_BYTES, ADDR_SPAN - 1), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = f12cc_pkg::CFG_DATA_START;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_cycles = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part with the reset register values. Entries for clusters
        // 0..3 are 0xFF8, 0xFFF, 0x000 and 0xFF7, so both sides of the
        // end-of-chain threshold are hit, and clusters 0 and 1 make the sector
        // sum wrap. Clusters 4094 and 4095 use the last three table bytes.
        write_byte(0, 8'hF8);
        write_byte(1, 8'hFF);
        write_byte(2, 8'hFF);
        write_byte(3, 8'h00);
        write_byte(4, 8'h70);
        write_byte(5, 8'hFF);
        write_byte(6141, 8'hBC);
        write_byte(6142, 8'h3A);
        write_byte(6143, 8'h5A);
        // Writes past the table end must leave the last entries untouched.
        write_byte(TABLE_BYTES, 8'h00);
        write_byte(ADDR_SPAN - 1, 8'hFF);
        follow(12'd0);
        follow(12'd1);
        follow(12'd2);
        follow(12'd3);
        follow(12'd4094);
        follow(12'd4095);
        drain(SETTLE_CYCLES);

        // Random phases. The sender idles 14 percent of the cycles in the first
        // two phases, 56 percent in the next two and never in the last two.
        // Register settings walk through both extremes of each register,
        // a zero sectors-per-cluster value and writes to the unused indexes.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct = 14;
                    program_regs(32'd0, 8'd1, 1'b0, CFG_UNUSED_LO);
                end
                1:
                begin
                    idle_pct = 14;
                    program_regs(32'hFFFF_FFFF, 8'd128, 1'b0, CFG_UNUSED_LO);
                end
                2:
                begin
                    idle_pct = 56;
                    program_regs(32'hFFFF_FFFE, 8'd0, 1'b0, CFG_UNUSED_LO);
                end
                3:
                begin
                    idle_pct = 56;
                    program_regs($urandom, 8'd255, 1'b1, CFG_UNUSED_LO);
                end
                4:
                begin
                    idle_pct = 0;
                    program_regs(32'd1000, 8'd8, 1'b1, CFG_UNUSED_HI);
                end
                default:
                begin
                    idle_pct = 0;
                    program_regs($urandom, 8'($urandom_range(1, 128)), 1'b0, CFG_UNUSED_LO);
                end
            endcase
            random_phase(PHASE_ITEMS);
            drain(SETTLE_CYCLES);
        end

        if (chain_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
